[design/trajectory_position_predictor_core_macros.svh]
// Assertion macros shared by the trajectory position predictor RTL.
// Included by the controller and the datapath; no other dependencies.
`ifndef TRAJECTORY_POSITION_PREDICTOR_CORE_MACROS_SVH
`define TRAJECTORY_POSITION_PREDICTOR_CORE_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked out of reset.
`define TPP_ASSERT_IMPLY(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: check failed");
// Next-cycle implication, checked out of reset.
`define TPP_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: check failed");
`else
`define TPP_ASSERT_IMPLY(name, clk, rst_n, ante, cons)
`define TPP_ASSERT_NEXT(name, clk, rst_n, ante, cons)
`endif

`endif

[design/tpp_pkg.sv]
// Types, constants and codes of the trajectory position predictor.
// Used by the controller, the datapath and the top level; no dependencies.
package tpp_pkg;

    localparam int DEF_MAX_WAYPOINTS = 16;

    localparam int POS_W     = 32;
    localparam int TIME_W    = 48;
    localparam int TGT_W     = TIME_W + 1;
    localparam int SPAN_W    = TIME_W + 1;
    localparam int ELAP_W    = TIME_W + 2;
    localparam int REM_W     = TIME_W + 2;
    localparam int DIFF_W    = POS_W + 1;
    localparam int MUL_W     = POS_W + 1;
    localparam int PROD_W    = 64;
    localparam int HI_W      = 48;
    localparam int SPLIT_W   = 32;
    localparam int FRAC_BITS = 16;
    localparam int FRAC_W    = FRAC_BITS + 1;
    localparam int DIV_CNT_W = $clog2(FRAC_BITS);
    localparam int Q_W       = 35;
    localparam int EXT_W     = Q_W + 2;
    localparam int ROUND_HALF = 32768;

    localparam logic [FRAC_W-1:0] FRAC_ONE  = FRAC_W'(1 << FRAC_BITS);
    localparam logic [FRAC_W-1:0] FRAC_ZERO = '0;
    localparam logic [Q_W-1:0]    Q_MAX     = {1'b1, {(Q_W-1){1'b0}}};
    localparam logic [POS_W-1:0]  POS_MAX   = {1'b0, {(POS_W-1){1'b1}}};
    localparam logic [POS_W-1:0]  POS_MIN   = {1'b1, {(POS_W-1){1'b0}}};

    typedef enum logic [1:0] {
        CMD_BEGIN  = 2'd0,
        CMD_APPEND = 2'd1,
        CMD_QUERY  = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        MUL_DX,
        MUL_DY,
        MUL_EXT_HI,
        MUL_EXT_LO
    } t_mul_sel;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_SCAN_RD,
        ST_SCAN_CMP,
        ST_SPAN,
        ST_FRAC,
        ST_DIV,
        ST_MUL_X,
        ST_MUL_Y,
        ST_LERP_Y,
        ST_EXT_HI,
        ST_EXT_LO,
        ST_EXT_SUM,
        ST_EXT_ADD,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [1:0]               cmd;
        logic signed [POS_W-1:0]  pos_x;
        logic signed [POS_W-1:0]  pos_y;
        logic signed [POS_W-1:0]  vel_x;
        logic signed [POS_W-1:0]  vel_y;
        logic signed [TIME_W-1:0] time_value;
    } t_in_item;

    typedef struct packed {
        logic signed [POS_W-1:0] out_x;
        logic signed [POS_W-1:0] out_y;
        logic                    from_trajectory;
        logic                    waypoints_dropped;
    } t_out_item;

    typedef struct packed {
        logic signed [TIME_W-1:0] wp_time;
        logic signed [POS_W-1:0]  wp_x;
        logic signed [POS_W-1:0]  wp_y;
    } t_waypoint;

    typedef struct packed {
        logic     load_item;
        logic     do_begin;
        logic     do_append;
        logic     start_query;
        logic     scan_read;
        logic     scan_step;
        logic     res_from_rd;
        logic     calc_span;
        logic     frac_check;
        logic     div_step;
        logic     mul_en;
        t_mul_sel mul_sel;
        logic     lerp_x;
        logic     lerp_y;
        logic     ext_hi_save;
        logic     ext_sum;
        logic     ext_add;
        logic     axis_y;
        logic     out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic [1:0] cmd;
        logic       count_zero;
        logic       found;
        logic       scan_last;
        logic       frac_trivial;
        logic       div_last;
        logic       out_free;
    } t_dp_status;

endpackage

[design/tpp_ctrl.sv]
// Sequencing state machine of the trajectory position predictor.
// Depends on tpp_pkg and the assertion macro header.
`include "trajectory_position_predictor_core_macros.svh"

module tpp_ctrl
    import tpp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   r_axis_y;
    logic   n_axis_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_axis_y <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_axis_y <= n_axis_y;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_axis_y = r_axis_y;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                n_axis_y = 1'b0;
                if (i_status.cmd == CMD_QUERY) begin
                    n_state = i_status.count_zero ? ST_EXT_HI : ST_SCAN_RD;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_SCAN_RD:  n_state = ST_SCAN_CMP;
            ST_SCAN_CMP: begin
                if (i_status.found) begin
                    n_state = ST_SPAN;
                end else if (i_status.scan_last) begin
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_SCAN_RD;
                end
            end
            ST_SPAN: n_state = ST_FRAC;
            ST_FRAC: n_state = i_status.frac_trivial ? ST_MUL_X : ST_DIV;
            ST_DIV: begin
                if (i_status.div_last) begin
                    n_state = ST_MUL_X;
                end
            end
            ST_MUL_X:   n_state = ST_MUL_Y;
            ST_MUL_Y:   n_state = ST_LERP_Y;
            ST_LERP_Y:  n_state = ST_DONE;
            ST_EXT_HI:  n_state = ST_EXT_LO;
            ST_EXT_LO:  n_state = ST_EXT_SUM;
            ST_EXT_SUM: n_state = ST_EXT_ADD;
            ST_EXT_ADD: begin
                if (r_axis_y) begin
                    n_state = ST_DONE;
                end else begin
                    n_axis_y = 1'b1;
                    n_state  = ST_EXT_HI;
                end
            end
            ST_DONE: begin
                if (i_status.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd        = '0;
        o_cmd.axis_y = r_axis_y;
        o_in_stall   = 1'b1;
        case (r_state)
            ST_IDLE: begin
                o_in_stall      = 1'b0;
                o_cmd.load_item = i_in_valid;
            end
            ST_DISPATCH: begin
                case (i_status.cmd)
                    CMD_BEGIN:  o_cmd.do_begin    = 1'b1;
                    CMD_APPEND: o_cmd.do_append   = 1'b1;
                    CMD_QUERY:  o_cmd.start_query = 1'b1;
                    default:    o_cmd.start_query = 1'b0;
                endcase
            end
            ST_SCAN_RD: o_cmd.scan_read = 1'b1;
            ST_SCAN_CMP: begin
                if (!i_status.found) begin
                    // Past the final waypoint the result is that waypoint.
                    o_cmd.res_from_rd = i_status.scan_last;
                    o_cmd.scan_step   = !i_status.scan_last;
                end
            end
            ST_SPAN: o_cmd.calc_span  = 1'b1;
            ST_FRAC: o_cmd.frac_check = 1'b1;
            ST_DIV:  o_cmd.div_step   = 1'b1;
            ST_MUL_X: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_DX;
            end
            ST_MUL_Y: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_DY;
                o_cmd.lerp_x  = 1'b1;
            end
            ST_LERP_Y: o_cmd.lerp_y = 1'b1;
            ST_EXT_HI: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_EXT_HI;
            end
            ST_EXT_LO: begin
                o_cmd.mul_en      = 1'b1;
                o_cmd.mul_sel     = MUL_EXT_LO;
                o_cmd.ext_hi_save = 1'b1;
            end
            ST_EXT_SUM: o_cmd.ext_sum  = 1'b1;
            ST_EXT_ADD: o_cmd.ext_add  = 1'b1;
            ST_DONE:    o_cmd.out_load = i_status.out_free;
            default:    o_in_stall     = 1'b1;
        endcase
    end

    `TPP_ASSERT_NEXT(a_accept_dispatch, i_clk, i_rst_n, i_in_valid && !o_in_stall, r_state == ST_DISPATCH)
    `TPP_ASSERT_NEXT(a_div_to_mul, i_clk, i_rst_n, r_state == ST_DIV && i_status.div_last, r_state == ST_MUL_X)
    `TPP_ASSERT_NEXT(a_done_release, i_clk, i_rst_n, r_state == ST_DONE && i_status.out_free, r_state == ST_IDLE)

endmodule

[design/tpp_datapath.sv]
// Datapath of the trajectory position predictor: observation state, waypoint
// memory, scan, serial divider, shared multiplier and output register. Uses tpp_pkg.
`include "trajectory_position_predictor_core_macros.svh"

module tpp_datapath
    import tpp_pkg::*;
#(
    parameter int MAX_WAYPOINTS = DEF_MAX_WAYPOINTS
)(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_in_item   i_in_item,
    input  t_dp_cmd    i_cmd,
    output t_dp_status o_status,
    input  logic       i_out_stall,
    output logic       o_out_valid,
    output t_out_item  o_out_item
);

    localparam int CNT_W = $clog2(MAX_WAYPOINTS + 1);
    localparam int IDX_W = (MAX_WAYPOINTS > 1) ? $clog2(MAX_WAYPOINTS) : 1;

    function automatic logic signed [POS_W-1:0] f_lerp(
        input logic signed [POS_W-1:0]  a_from,
        input logic signed [PROD_W-1:0] a_prod
    );
        logic signed [PROD_W-1:0] v_rnd;
        logic signed [PROD_W-1:0] v_sh;
        v_rnd = a_prod + PROD_W'(ROUND_HALF);
        v_sh  = v_rnd >>> FRAC_BITS;
        return a_from + v_sh[POS_W-1:0];
    endfunction

    // Observation state and table bookkeeping.
    t_in_item                 r_item;
    logic signed [POS_W-1:0]  r_base_x;
    logic signed [POS_W-1:0]  r_base_y;
    logic [POS_W-1:0]         r_vmag_x;
    logic [POS_W-1:0]         r_vmag_y;
    logic                     r_vneg_x;
    logic                     r_vneg_y;
    logic signed [TIME_W-1:0] r_obs_time;
    logic [CNT_W-1:0]         r_count;
    logic                     r_overflow;

    t_waypoint                r_mem [MAX_WAYPOINTS];
    t_waypoint                r_rd;
    logic [IDX_W-1:0]         r_idx;

    // Query working registers.
    logic signed [TGT_W-1:0]  r_target;
    logic [TIME_W-1:0]        r_smag;
    logic                     r_sneg;
    logic signed [TIME_W-1:0] r_prev_t;
    logic signed [POS_W-1:0]  r_from_x;
    logic signed [POS_W-1:0]  r_from_y;
    logic signed [ELAP_W-1:0] r_elapsed;
    logic signed [SPAN_W-1:0] r_span;
    logic signed [DIFF_W-1:0] r_dx;
    logic signed [DIFF_W-1:0] r_dy;
    logic [FRAC_W-1:0]        r_frac;
    logic [REM_W-1:0]         r_rem;
    logic [DIV_CNT_W-1:0]     r_div_cnt;
    logic signed [PROD_W-1:0] r_prod;
    logic [HI_W-1:0]          r_hi;
    logic [Q_W-1:0]           r_q;
    logic signed [POS_W-1:0]  r_res_x;
    logic signed [POS_W-1:0]  r_res_y;
    logic                     r_traj;
    t_out_item                r_out;
    logic                     r_out_valid;

    logic                     v_full;
    logic                     v_found;
    logic                     v_le0;
    logic                     v_ge;
    logic [REM_W-1:0]         v_rem2;
    logic [REM_W-1:0]         v_span_u;
    logic                     v_qbit;
    logic signed [MUL_W-1:0]  v_ma;
    logic signed [MUL_W-1:0]  v_mb;
    logic signed [2*MUL_W-1:0] v_prod;
    logic [POS_W-1:0]         v_vmag;
    logic [PROD_W-1:0]        v_sum;
    logic [HI_W-1:0]          v_q48;
    logic signed [EXT_W-1:0]  v_qs;
    logic signed [EXT_W-1:0]  v_ext;
    logic                     v_neg;
    logic                     v_fit;
    logic signed [POS_W-1:0]  v_ext_res;

    assign v_full   = (r_count == CNT_W'(MAX_WAYPOINTS));
    assign v_found  = (r_target <= TGT_W'(r_rd.wp_time));
    assign v_le0    = r_elapsed[ELAP_W-1] || (r_elapsed == '0);
    assign v_ge     = (r_elapsed >= ELAP_W'(r_span));
    assign v_rem2   = {r_rem[REM_W-2:0], 1'b0};
    assign v_span_u = REM_W'($unsigned(r_span));
    assign v_qbit   = (v_rem2 >= v_span_u);

    assign o_status.cmd          = r_item.cmd;
    assign o_status.count_zero   = (r_count == '0);
    assign o_status.found        = v_found;
    assign o_status.scan_last    = ((CNT_W'(r_idx) + CNT_W'(1)) == r_count);
    assign o_status.frac_trivial = v_le0 || v_ge;
    assign o_status.div_last     = (r_div_cnt == DIV_CNT_W'(FRAC_BITS - 1));
    assign o_status.out_free     = !r_out_valid || !i_out_stall;

    // One shared signed multiplier; magnitudes are fed in zero-extended.
    always_comb begin
        v_vmag = i_cmd.axis_y ? r_vmag_y : r_vmag_x;
        case (i_cmd.mul_sel)
            MUL_DX: begin
                v_ma = r_dx;
                v_mb = $signed(MUL_W'(r_frac));
            end
            MUL_DY: begin
                v_ma = r_dy;
                v_mb = $signed(MUL_W'(r_frac));
            end
            MUL_EXT_HI: begin
                v_ma = $signed(MUL_W'(v_vmag));
                v_mb = $signed(MUL_W'(r_smag[TIME_W-1:SPLIT_W]));
            end
            MUL_EXT_LO: begin
                v_ma = $signed(MUL_W'(v_vmag));
                v_mb = $signed(MUL_W'(r_smag[SPLIT_W-1:0]));
            end
            default: begin
                v_ma = '0;
                v_mb = '0;
            end
        endcase
        v_prod = v_ma * v_mb;
    end

    // Rounded product, clamped, then added to the base with saturation.
    always_comb begin
        v_sum = {r_hi[PROD_W-SPLIT_W-1:0], {SPLIT_W{1'b0}}} + $unsigned(r_prod)
              + PROD_W'(ROUND_HALF);
        v_q48 = v_sum[PROD_W-1:FRAC_BITS];
        v_neg = (i_cmd.axis_y ? r_vneg_y : r_vneg_x) ^ r_sneg;
        v_qs  = $signed(EXT_W'(r_q));
        v_ext = EXT_W'(i_cmd.axis_y ? r_base_y : r_base_x) + (v_neg ? -v_qs : v_qs);
        v_fit = (&v_ext[EXT_W-1:POS_W-1]) || !(|v_ext[EXT_W-1:POS_W-1]);
        if (v_fit) begin
            v_ext_res = v_ext[POS_W-1:0];
        end else begin
            v_ext_res = v_ext[EXT_W-1] ? POS_MIN : POS_MAX;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_x   <= '0;
            r_base_y   <= '0;
            r_vmag_x   <= '0;
            r_vmag_y   <= '0;
            r_vneg_x   <= 1'b0;
            r_vneg_y   <= 1'b0;
            r_obs_time <= '0;
            r_count    <= '0;
            r_overflow <= 1'b0;
        end else if (i_cmd.do_begin) begin
            r_base_x   <= r_item.pos_x;
            r_base_y   <= r_item.pos_y;
            r_vmag_x   <= r_item.vel_x[POS_W-1] ? POS_W'(-r_item.vel_x) : r_item.vel_x;
            r_vmag_y   <= r_item.vel_y[POS_W-1] ? POS_W'(-r_item.vel_y) : r_item.vel_y;
            r_vneg_x   <= r_item.vel_x[POS_W-1];
            r_vneg_y   <= r_item.vel_y[POS_W-1];
            r_obs_time <= r_item.time_value;
            r_count    <= '0;
            r_overflow <= 1'b0;
        end else if (i_cmd.do_append) begin
            if (v_full) begin
                r_overflow <= 1'b1;
            end else begin
                r_count <= r_count + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.do_append && !v_full) begin
            r_mem[r_count[IDX_W-1:0]] <= '{wp_time: r_item.time_value,
                                          wp_x:    r_item.pos_x,
                                          wp_y:    r_item.pos_y};
        end
        if (i_cmd.scan_read) begin
            r_rd <= r_mem[r_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_item <= i_in_item;
        end
        if (i_cmd.start_query) begin
            r_target <= TGT_W'(r_obs_time) + TGT_W'(r_item.time_value);
            r_smag   <= r_item.time_value[TIME_W-1] ? TIME_W'(-r_item.time_value)
                                                    : r_item.time_value;
            r_sneg   <= r_item.time_value[TIME_W-1];
            r_prev_t <= r_obs_time;
            r_from_x <= r_base_x;
            r_from_y <= r_base_y;
            r_idx    <= '0;
            r_traj   <= (r_count != '0);
        end
        if (i_cmd.scan_step) begin
            r_prev_t <= r_rd.wp_time;
            r_from_x <= r_rd.wp_x;
            r_from_y <= r_rd.wp_y;
            r_idx    <= r_idx + IDX_W'(1);
        end
        if (i_cmd.calc_span) begin
            r_elapsed <= ELAP_W'(r_target) - ELAP_W'(r_prev_t);
            r_span    <= SPAN_W'(r_rd.wp_time) - SPAN_W'(r_prev_t);
            r_dx      <= DIFF_W'(r_rd.wp_x) - DIFF_W'(r_from_x);
            r_dy      <= DIFF_W'(r_rd.wp_y) - DIFF_W'(r_from_y);
        end
        if (i_cmd.frac_check) begin
            r_rem     <= $unsigned(r_elapsed);
            r_div_cnt <= '0;
            if (v_le0) begin
                r_frac <= FRAC_ZERO;
            end else if (v_ge) begin
                r_frac <= FRAC_ONE;
            end else begin
                r_frac <= FRAC_ZERO;
            end
        end
        if (i_cmd.div_step) begin
            r_frac    <= {r_frac[FRAC_W-2:0], v_qbit};
            r_rem     <= v_qbit ? (v_rem2 - v_span_u) : v_rem2;
            r_div_cnt <= r_div_cnt + DIV_CNT_W'(1);
        end
        if (i_cmd.mul_en) begin
            r_prod <= v_prod[PROD_W-1:0];
        end
        if (i_cmd.ext_hi_save) begin
            r_hi <= $unsigned(r_prod[HI_W-1:0]);
        end
        if (i_cmd.ext_sum) begin
            // A high partial product of 2^16 or more already puts the result out of range.
            if (|r_hi[HI_W-1:FRAC_BITS]) begin
                r_q <= Q_MAX;
            end else if (v_q48 > HI_W'(Q_MAX)) begin
                r_q <= Q_MAX;
            end else begin
                r_q <= v_q48[Q_W-1:0];
            end
        end
        if (i_cmd.res_from_rd) begin
            r_res_x <= r_rd.wp_x;
            r_res_y <= r_rd.wp_y;
        end
        if (i_cmd.lerp_x) begin
            r_res_x <= f_lerp(r_from_x, r_prod);
        end
        if (i_cmd.lerp_y) begin
            r_res_y <= f_lerp(r_from_y, r_prod);
        end
        if (i_cmd.ext_add) begin
            if (i_cmd.axis_y) begin
                r_res_y <= v_ext_res;
            end else begin
                r_res_x <= v_ext_res;
            end
        end
        if (i_cmd.out_load) begin
            r_out <= '{out_x:             r_res_x,
                       out_y:             r_res_y,
                       from_trajectory:   r_traj,
                       waypoints_dropped: r_overflow};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    `TPP_ASSERT_IMPLY(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(MAX_WAYPOINTS))
    `TPP_ASSERT_NEXT(a_full_drop, i_clk, i_rst_n, i_cmd.do_append && v_full, r_overflow && $stable(r_count))
    `TPP_ASSERT_NEXT(a_load_valid, i_clk, i_rst_n, i_cmd.out_load, o_out_valid && o_out_item.from_trajectory == $past(r_traj))

endmodule

[design/trajectory_position_predictor_core.sv]
// Top level of the trajectory position predictor.
// Depends on tpp_pkg, tpp_ctrl and tpp_datapath.
//
// Begin items store an observation and empty the waypoint table, append items
// add waypoints (extra ones are dropped and flagged), and each query returns one
// predicted position. Items are taken one at a time. A query without waypoints
// uses a 32x16 and a 32x32 multiply per axis on one shared multiplier; a query
// finds its span by scanning the waypoints, then runs the divider unless the
// fraction is 0 or 1; a query that runs past the last waypoint needs neither.
// The waypoint memory is read through its single registered read port, and the
// 16-step bit-serial divider gives the interpolation fraction. A finished result
// waits in the output register while the next item is accepted.
module trajectory_position_predictor_core
    import tpp_pkg::*;
#(
    parameter int MAX_WAYPOINTS = DEF_MAX_WAYPOINTS
)(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    tpp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    tpp_datapath #(
        .MAX_WAYPOINTS (MAX_WAYPOINTS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_item   (i_in_item),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

endmodule
